// File: rtl/rrha_pkg.sv
package rrha_pkg;

  // Field and state widths.
  localparam int unsigned PosW     = 32;
  localparam int unsigned RateW    = 16;
  localparam int unsigned HistDepth = 5;
  localparam int unsigned IdxW     = $clog2(HistDepth);
  localparam int unsigned ZcW      = $clog2(HistDepth + 1);
  localparam int unsigned SumW     = RateW + $clog2(HistDepth);

  // The shared divider takes a dividend of DivW bits. It covers both the history sum and
  // the rate numerator 60 * samples per second for every allowed sample rate.
  localparam int unsigned SpsDefault = 360;
  localparam int unsigned SpsMax     = 2000;
  localparam int unsigned NumMaxW    = $clog2(60 * SpsMax + 1);
  localparam int unsigned DivW       = (SumW > NumMaxW) ? SumW : NumMaxW;
  localparam int unsigned CntW       = $clog2(DivW + 1);

  // Configuration register indexes and reset values.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgMinRate = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxRate = 1'b1;
  localparam logic [RateW-1:0] MinRateReset = 16'd40;
  localparam logic [RateW-1:0] MaxRateReset = 16'd201;
  localparam logic [RateW-1:0] RateSat      = 16'hFFFF;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE_DIV,
    ST_CHECK,
    ST_SUM,
    ST_AVG_DIV,
    ST_DONE
  } state_e;

endpackage

// File: rtl/rr_interval_heart_rate_averager_top.sv
// Heart-rate averager over RR intervals.
// Input channel: in_valid_i / in_stall_o with the current and previous QRS sample
// positions. An item is taken at a clock edge where in_valid_i is high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with the averaged rate, the beat rate, the
// accept flag and the beat valid flag. Every item gives exactly one result.
// Configuration: cfg_we_i writes cfg_data_i into min_rate (index 0) or max_rate (index 1).
// Steps: an item with a missing position goes straight to the result load. A full beat
// runs the shared restoring divider for the rate, then the acceptance check, then sums
// the history one entry at a time, runs the divider again for the average and loads
// the result. A zero interval skips the rate division.
// Throughput: one item at a time. in_stall_o is high while an item is being worked on.
// The result sits in an output register, so the next item is taken while a result
// still waits there. If the receiver stalls, the result holds and a finished second
// item waits inside the block until the output register frees.
// Reset clears the history, the held rate and the average to zero, and sets min_rate
// to 40 and max_rate to 201.
module rr_interval_heart_rate_averager_top #(
  parameter int unsigned SAMPLES_PER_SECOND = rrha_pkg::SpsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rrha_pkg::PosW-1:0]     qrs_position_i,
  input  logic [rrha_pkg::PosW-1:0]     previous_qrs_position_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rrha_pkg::RateW-1:0]    average_rate_o,
  output logic [rrha_pkg::RateW-1:0]    beat_rate_o,
  output logic                          rate_accepted_o,
  output logic                          beat_valid_o,
  input  logic                          cfg_we_i,
  input  logic [rrha_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rrha_pkg::RateW-1:0]    cfg_data_i
);
  import rrha_pkg::*;

  localparam int unsigned RateNum = 60 * SAMPLES_PER_SECOND;

  state_e state_q, state_d;

  logic [RateW-1:0] min_q, max_q;
  logic [RateW-1:0] held_q, held_d;
  logic [RateW-1:0] avg_q, avg_d;
  logic [RateW-1:0] hist_q [HistDepth];
  logic [RateW-1:0] hist_d [HistDepth];
  logic [RateW-1:0] rate_q, rate_d;
  logic             acc_q, acc_d;
  logic             bv_q, bv_d;

  // Shared divider registers: dividend shifts out as the quotient shifts in.
  logic [DivW-1:0]  dq_q, dq_d;
  logic [PosW-1:0]  rem_q, rem_d;
  logic [PosW-1:0]  div_q, div_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic [IdxW-1:0]  idx_q, idx_d;
  logic [ZcW-1:0]   zc_q, zc_d;
  logic [SumW-1:0]  sum_q, sum_d;

  logic             out_valid_q, out_valid_d;
  logic [RateW-1:0] out_avg_q, out_avg_d;
  logic [RateW-1:0] out_rate_q, out_rate_d;
  logic             out_acc_q, out_acc_d;
  logic             out_bv_q, out_bv_d;

  // One restoring division step.
  logic [PosW:0]    trial;
  logic             trial_ge;
  logic [PosW:0]    trial_diff;
  logic [PosW-1:0]  rem_step;
  logic [DivW-1:0]  dq_step;

  assign trial      = {rem_q, dq_q[DivW-1]};
  assign trial_ge   = trial >= {1'b0, div_q};
  assign trial_diff = trial - {1'b0, div_q};
  assign rem_step   = trial_ge ? trial_diff[PosW-1:0] : trial[PosW-1:0];
  assign dq_step    = {dq_q[DivW-2:0], trial_ge};

  // Plausibility test of the new rate against the running average.
  logic [RateW+3:0] avg7, rate10, rate5;
  logic             in_ratio, in_band, accept;

  assign avg7     = ((RateW+4)'(avg_q) << 3) - (RateW+4)'(avg_q);
  assign rate10   = ((RateW+4)'(rate_q) << 3) + ((RateW+4)'(rate_q) << 1);
  assign rate5    = ((RateW+4)'(rate_q) << 2) + (RateW+4)'(rate_q);
  assign in_ratio = (avg7 <= rate10) && (rate5 <= avg7);
  assign in_band  = (rate_q <= max_q) && (rate_q >= min_q);
  assign accept   = (held_q == '0) || in_ratio || (avg_q == '0) || in_band;

  logic [PosW-1:0]  interval;
  logic             both_nz;
  logic [SumW-1:0]  sum_next;
  logic [RateW-1:0] held_new;
  logic [ZcW-1:0]   zc_new;

  assign interval = qrs_position_i - previous_qrs_position_i;
  assign both_nz  = (qrs_position_i != '0) && (previous_qrs_position_i != '0);
  assign sum_next = sum_q + SumW'(hist_q[idx_q]);
  assign held_new = accept ? rate_q : held_q;

  // Zero entries of the history after the shift.
  always_comb begin
    zc_new = '0;
    for (int i = 0; i < HistDepth - 1; i++) begin
      zc_new = zc_new + ZcW'(hist_q[i+1] == '0);
    end
    zc_new = zc_new + ZcW'(held_new == '0);
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    avg_d       = avg_q;
    hist_d      = hist_q;
    rate_d      = rate_q;
    acc_d       = acc_q;
    bv_d        = bv_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    div_d       = div_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    zc_d        = zc_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_avg_d   = out_avg_q;
    out_rate_d  = out_rate_q;
    out_acc_d   = out_acc_q;
    out_bv_d    = out_bv_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          acc_d = 1'b0;
          bv_d  = both_nz;
          if (!both_nz) begin
            avg_d   = '0;
            rate_d  = '0;
            state_d = ST_DONE;
          end else if (interval == '0) begin
            rate_d  = RateSat;
            state_d = ST_CHECK;
          end else begin
            dq_d    = DivW'(RateNum);
            rem_d   = '0;
            div_d   = interval;
            cnt_d   = CntW'(DivW);
            state_d = ST_RATE_DIV;
          end
        end
      end
      ST_RATE_DIV: begin
        if (cnt_q != '0) begin
          dq_d  = dq_step;
          rem_d = rem_step;
          cnt_d = cnt_q - 1'b1;
        end else begin
          rate_d  = (dq_q[DivW-1:RateW] != '0) ? RateSat : dq_q[RateW-1:0];
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        acc_d  = accept;
        held_d = held_new;
        for (int i = 0; i < HistDepth - 1; i++) begin
          hist_d[i] = hist_q[i+1];
        end
        hist_d[HistDepth-1] = held_new;
        zc_d  = zc_new;
        idx_d = IdxW'(zc_new);
        sum_d = '0;
        if (zc_new == ZcW'(HistDepth)) begin
          avg_d   = '0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_d = sum_next;
        if (idx_q == IdxW'(HistDepth - 1)) begin
          dq_d    = DivW'(sum_next);
          rem_d   = '0;
          div_d   = PosW'(ZcW'(HistDepth) - zc_q);
          cnt_d   = CntW'(DivW);
          state_d = ST_AVG_DIV;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_AVG_DIV: begin
        if (cnt_q != '0) begin
          dq_d  = dq_step;
          rem_d = rem_step;
          cnt_d = cnt_q - 1'b1;
        end else begin
          avg_d   = dq_q[RateW-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_avg_d   = avg_q;
          out_rate_d  = rate_q;
          out_acc_d   = acc_q;
          out_bv_d    = bv_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state and beat state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      held_q      <= '0;
      avg_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      zc_q        <= '0;
      for (int i = 0; i < HistDepth; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      held_q      <= held_d;
      avg_q       <= avg_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      zc_q        <= zc_d;
      hist_q      <= hist_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MinRateReset;
      max_q <= MaxRateReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgMinRate: min_q <= cfg_data_i;
        CfgMaxRate: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rate_q     <= rate_d;
    acc_q      <= acc_d;
    bv_q       <= bv_d;
    dq_q       <= dq_d;
    rem_q      <= rem_d;
    div_q      <= div_d;
    sum_q      <= sum_d;
    out_avg_q  <= out_avg_d;
    out_rate_q <= out_rate_d;
    out_acc_q  <= out_acc_d;
    out_bv_q   <= out_bv_d;
  end

  assign out_valid_o     = out_valid_q;
  assign average_rate_o  = out_avg_q;
  assign beat_rate_o     = out_rate_q;
  assign rate_accepted_o = out_acc_q;
  assign beat_valid_o    = out_bv_q;

endmodule

// File: rtl/rrha_checker.sv
module rrha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] average_rate_o,
  input logic [15:0] beat_rate_o,
  input logic        rate_accepted_o,
  input logic        beat_valid_o
);

  // Only one item is worked on at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is still in work");

  // A result without a beat carries no rate and no acceptance.
  a_no_beat_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !beat_valid_o |-> beat_rate_o == 16'd0 && !rate_accepted_o)
    else $error("rate fields set on a result without a beat");

  // A missing position clears the average.
  a_no_beat_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !beat_valid_o |-> average_rate_o == 16'd0)
    else $error("average not cleared on a missing position");

  // An accepted rate always comes from a valid beat.
  a_accept_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rate_accepted_o |-> beat_valid_o)
    else $error("rate accepted without a valid beat");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(average_rate_o))
    else $error("stalled result changed");

endmodule

bind rr_interval_heart_rate_averager_top rrha_checker u_rrha_checker (.*);

// File: sim/rrha_beat_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the configuration port of the averager. For each
// accepted item it works out the expected result and compares it with the
// results that leave the block, oldest first.
module rrha_beat_checker #(
  parameter int unsigned SAMPLES_PER_SECOND = rrha_pkg::SpsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [rrha_pkg::PosW-1:0]     qrs_position_i,
  input  logic [rrha_pkg::PosW-1:0]     previous_qrs_position_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [rrha_pkg::RateW-1:0]    average_rate_i,
  input  logic [rrha_pkg::RateW-1:0]    beat_rate_i,
  input  logic                          rate_accepted_i,
  input  logic                          beat_valid_i,
  input  logic                          cfg_we_i,
  input  logic [rrha_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rrha_pkg::RateW-1:0]    cfg_data_i,
  output int                            pending_o,
  output int                            errors_o
);
  import rrha_pkg::*;

  typedef struct packed {
    logic [RateW-1:0] average_rate;
    logic [RateW-1:0] beat_rate;
    logic             rate_accepted;
    logic             beat_valid;
  } beat_result_t;

  // Mirror of the block's state and registers.
  logic [RateW-1:0] min_rate_q;
  logic [RateW-1:0] max_rate_q;
  logic [RateW-1:0] held_rate_q;
  logic [RateW-1:0] average_q;
  logic [RateW-1:0] history_q [HistDepth];

  beat_result_t expected_beats [$];
  int           mismatches = 0;

  // Instantaneous rate in beats per minute for an interval in samples.
  function automatic logic [RateW-1:0] rate_of_interval(input logic [PosW-1:0] interval);
    logic [PosW-1:0] quotient;
    if (interval == '0) begin
      return RateSat;
    end
    quotient = (60 * SAMPLES_PER_SECOND) / interval;
    if (quotient > 32'h0000_FFFF) begin
      return RateSat;
    end
    return quotient[RateW-1:0];
  endfunction

  // Advances the mirrored state by one item and queues the result it causes.
  task automatic predict_beat(input logic [PosW-1:0] cur, input logic [PosW-1:0] prev);
    beat_result_t res;
    logic [31:0]  r;
    logic [31:0]  avg;
    logic [31:0]  sum;
    int           zeros;
    res = '0;
    if (cur != '0 && prev != '0) begin
      res.beat_valid = 1'b1;
      res.beat_rate  = rate_of_interval(cur - prev);
      r   = res.beat_rate;
      avg = average_q;
      // Plausibility test against the average and the configured band.
      if (held_rate_q == '0 || (7 * avg <= 10 * r && 5 * r <= 7 * avg) || avg == 0 ||
          (r >= min_rate_q && r <= max_rate_q)) begin
        res.rate_accepted = 1'b1;
        held_rate_q = res.beat_rate;
      end
      for (int i = 0; i < HistDepth - 1; i++) begin
        history_q[i] = history_q[i+1];
      end
      history_q[HistDepth-1] = held_rate_q;
      // The zero count picks the start position, not the nonzero entries.
      zeros = 0;
      sum   = 0;
      for (int i = 0; i < HistDepth; i++) begin
        if (history_q[i] == '0) begin
          zeros++;
        end
      end
      for (int i = zeros; i < HistDepth; i++) begin
        sum += history_q[i];
      end
      average_q = (zeros >= HistDepth) ? '0 : RateW'(sum / (HistDepth - zeros));
    end else begin
      average_q = '0;
    end
    res.average_rate = average_q;
    expected_beats.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [RateW-1:0] want,
                             input logic [RateW-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Compare leaving results, follow register writes, predict accepted items.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    beat_result_t want;
    if (!rst_ni) begin
      min_rate_q  = MinRateReset;
      max_rate_q  = MaxRateReset;
      held_rate_q = '0;
      average_q   = '0;
      for (int i = 0; i < HistDepth; i++) begin
        history_q[i] = '0;
      end
      expected_beats.delete();
      pending_o <= 0;
      errors_o  <= mismatches;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          $display("%0t: result with no item pending, average_rate %0d beat_rate %0d",
                   $time, average_rate_i, beat_rate_i);
        end else begin
          want = expected_beats.pop_front();
          check_field("average_rate", want.average_rate, average_rate_i);
          check_field("beat_rate", want.beat_rate, beat_rate_i);
          check_field("rate_accepted", RateW'(want.rate_accepted), RateW'(rate_accepted_i));
          check_field("beat_valid", RateW'(want.beat_valid), RateW'(beat_valid_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgMinRate: begin
            min_rate_q = cfg_data_i;
          end
          CfgMaxRate: begin
            max_rate_q = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_beat(qrs_position_i, previous_qrs_position_i);
      end
      pending_o <= expected_beats.size();
      errors_o  <= mismatches;
    end
  end

endmodule

// File: sim/tb_rr_interval_heart_rate_averager_top.sv
`timescale 1ns / 1ps

module tb_rr_interval_heart_rate_averager_top;
  import rrha_pkg::*;

  // Samples per minute at the default sample rate.
  localparam int BeatScale = 60 * SpsDefault;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PosW-1:0]    qrs_pos = '0;
  logic [PosW-1:0]    prev_pos = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [RateW-1:0]   average_rate;
  logic [RateW-1:0]   beat_rate;
  logic               rate_accepted;
  logic               beat_valid;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CfgMinRate;
  logic [RateW-1:0]   cfg_data = '0;

  int                 pending_beats;
  int                 mismatch_total;

  // Recording that the random beats follow.
  logic [PosW-1:0]    stream_pos = 32'd1000;
  int                 base_rate = 72;
  logic               quiet = 1'b0;

  rr_interval_heart_rate_averager_top dut (
    .clk_i                   (clk),
    .rst_ni                  (rst_n),
    .in_valid_i              (in_valid),
    .in_stall_o              (in_stall),
    .qrs_position_i          (qrs_pos),
    .previous_qrs_position_i (prev_pos),
    .out_valid_o             (out_valid),
    .out_stall_i             (out_stall),
    .average_rate_o          (average_rate),
    .beat_rate_o             (beat_rate),
    .rate_accepted_o         (rate_accepted),
    .beat_valid_o            (beat_valid),
    .cfg_we_i                (cfg_we),
    .cfg_index_i             (cfg_index),
    .cfg_data_i              (cfg_data)
  );

  rrha_beat_checker #(
    .SAMPLES_PER_SECOND (SpsDefault)
  ) beat_check (
    .clk_i                   (clk),
    .rst_ni                  (rst_n),
    .in_valid_i              (in_valid),
    .in_stall_i              (in_stall),
    .qrs_position_i          (qrs_pos),
    .previous_qrs_position_i (prev_pos),
    .out_valid_i             (out_valid),
    .out_stall_i             (out_stall),
    .average_rate_i          (average_rate),
    .beat_rate_i             (beat_rate),
    .rate_accepted_i         (rate_accepted),
    .beat_valid_i            (beat_valid),
    .cfg_we_i                (cfg_we),
    .cfg_index_i             (cfg_index),
    .cfg_data_i              (cfg_data),
    .pending_o               (pending_beats),
    .errors_o                (mismatch_total)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Safety net against a hung handshake.
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end
    if (roll < 85) begin
      return $urandom_range(1, 3);
    end
    if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 80);
  endfunction

  // Sends one item after an optional idle gap and returns at its accepting edge.
  task automatic feed_beat(input logic [PosW-1:0] cur, input logic [PosW-1:0] prev);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    qrs_pos  <= cur;
    prev_pos <= prev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Holds the sender back until every result has left the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_rate_band(input logic [RateW-1:0] lo, input logic [RateW-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CfgMinRate;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CfgMaxRate;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly regular beats of a drifting rhythm, with ectopic beats, dropouts,
  // degenerate intervals and plain noise mixed in.
  task automatic pick_random_beat(output logic [PosW-1:0] cur, output logic [PosW-1:0] prev);
    int roll;
    int interval;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) begin
      stream_pos = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 4000)
                                               : $urandom;
      base_rate  = $urandom_range(30, 220);
    end
    base_rate = base_rate + $urandom_range(0, 10) - 5;
    if (base_rate < 25) begin
      base_rate = 25;
    end
    if (base_rate > 250) begin
      base_rate = 250;
    end
    interval = BeatScale / base_rate;
    interval = interval + $urandom_range(0, interval / 8) - interval / 16;
    prev = stream_pos;
    if (roll < 70) begin
      cur = stream_pos + interval;
    end else if (roll < 78) begin
      cur = stream_pos + (($urandom_range(0, 1) == 1) ? interval / 2 : interval * 2);
    end else if (roll < 87) begin
      cur = stream_pos + $urandom_range(1, 400);
    end else if (roll < 91) begin
      cur = stream_pos;
    end else if (roll < 95) begin
      cur = stream_pos + interval;
      case ($urandom_range(0, 2))
        0: begin
          cur = '0;
        end
        1: begin
          prev = '0;
        end
        default: begin
          cur  = '0;
          prev = '0;
        end
      endcase
    end else begin
      cur  = $urandom;
      prev = $urandom;
    end
    if (roll < 95 && cur != '0) begin
      stream_pos = cur;
    end
  endtask

  // Receiver: random stalls, with long open stretches now and then.
  initial begin : receiver
    int len;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        out_stall <= 1'b0;
        len = $urandom_range(50, 300);
      end else begin
        out_stall <= ($urandom_range(0, 9) < 4);
        len = 1 + pick_gap();
      end
      repeat (len) @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    logic [PosW-1:0]  cur;
    logic [PosW-1:0]  prev;
    logic [RateW-1:0] lo;
    logic [RateW-1:0] hi;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset band.
    feed_beat(32'd0, 32'd0);
    feed_beat(32'd0, 32'd1000);
    feed_beat(32'd1000, 32'd0);
    feed_beat(32'd1360, 32'd1000);              // first beat, nothing held yet
    feed_beat(32'd1720, 32'd1360);
    feed_beat(32'd2080, 32'd1720);
    feed_beat(32'd2080, 32'd2080);              // zero interval saturates
    feed_beat(32'd2081, 32'd2080);              // one-sample interval
    feed_beat(32'h0000_0064, 32'hFFFF_FF00);    // positions wrap around
    feed_beat(32'hFFFF_FFFF, 32'd1);            // huge interval gives rate 0
    feed_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    feed_beat(32'd1, 32'hFFFF_FFFF);            // very short interval across the wrap
    feed_beat(32'd3000, 32'd2743);              // upper edge of the ratio window
    feed_beat(32'd4000, 32'd3520);              // lower edge of the ratio window
    feed_beat(32'd5000, 32'd4280);              // slow beat below the band
    feed_beat(32'd5090, 32'd5000);              // fast beat above the band
    feed_beat(32'd0, 32'd5090);                 // dropout clears the average
    feed_beat(32'd5162, 32'd5090);              // taken because the average is 0
    feed_beat(32'd5522, 32'd5162);

    // Random phases under various rate bands; phases 0 and 5 use the reset band.
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase)
        1: begin
          lo = '0;
          hi = 16'hFFFF;
        end
        2: begin
          lo = 16'hFFFF;
          hi = '0;
        end
        3: begin
          lo = 16'd60;
          hi = 16'd100;
        end
        4: begin
          lo = $urandom_range(0, 65535);
          hi = $urandom_range(0, 65535);
        end
        default: begin
          lo = MinRateReset;
          hi = MaxRateReset;
        end
      endcase
      if (phase > 0) begin
        set_rate_band(lo, hi);
      end
      for (int n = 0; n < 250; n++) begin
        if (n % 40 == 0) begin
          quiet = ($urandom_range(0, 3) == 0);
        end
        if (n == 125 || $urandom_range(0, 199) == 0) begin
          wait_idle();
        end
        pick_random_beat(cur, prev);
        feed_beat(cur, prev);
      end
    end

    wait_idle();
    repeat (60) @(posedge clk);
    if (mismatch_total == 0 && pending_beats == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
